// ===== rtl/dpw_pkg.sv =====
`default_nettype none

package dpw_pkg;

  localparam int DEF_RECORD_DEPTH = 65536;
  localparam int DEF_MAX_CHILDREN = 64;

  localparam int ADDR_W   = 16;
  localparam int RECORD_W = 32;
  localparam int LETTER_W = 7;
  localparam int LINK_W   = 24;

  // Record layout
  localparam int REC_MORE_BIT  = 31;
  localparam int REC_LETTER_LO = 24;
  localparam int REC_LETTER_HI = 30;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_WALK  = 2'd1,
    OP_WORD  = 2'd2,
    OP_LIST  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [ADDR_W-1:0]   address;
    logic [RECORD_W-1:0] record_word;
    logic [LETTER_W-1:0] letter;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [LETTER_W-1:0] child_letter;
    logic                empty_list;
    logic                truncated;
    logic                last_result;
  } out_item_t;

  // Decoded request handed from the front to the back
  typedef struct packed {
    op_t                 op;
    logic                addr_ok;
    logic [ADDR_W-1:0]   address;
    logic [RECORD_W-1:0] record_word;
    logic [LETTER_W-1:0] letter;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/dpw_ram.sv =====
`default_nettype none

module dpw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dpw_front.sv =====
`default_nettype none

module dpw_front
  import dpw_pkg::*;
#(
  parameter int RECORD_DEPTH = DEF_RECORD_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output      logic     full,
  input  wire in_item_t item,
  output      logic     cmd_valid,
  input  wire logic     cmd_ready,
  output      cmd_t     cmd
);

  localparam logic [LINK_W:0] DEPTH_X = (LINK_W+1)'(RECORD_DEPTH);

  cmd_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  cmd_t       dec;
  logic       do_push;
  logic       do_pop;

  // Classify: decode opcode, flag writes that fall outside the store
  always_comb begin
    dec.op          = op_t'(item.opcode);
    dec.addr_ok     = ((LINK_W+1)'(item.address) < DEPTH_X);
    dec.address     = item.address;
    dec.record_word = item.record_word;
    dec.letter      = item.letter;
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= dec;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dpw_back.sv =====
`default_nettype none

module dpw_back
  import dpw_pkg::*;
#(
  parameter int RECORD_DEPTH = DEF_RECORD_DEPTH,
  parameter int MAX_CHILDREN = DEF_MAX_CHILDREN
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output      logic      cmd_ready,
  input  wire cmd_t      cmd,
  output      logic      empty,
  input  wire logic      pop,
  output      out_item_t result
);

  localparam int AW = $clog2(RECORD_DEPTH);
  localparam int CW = $clog2(MAX_CHILDREN + 1);
  localparam logic [LINK_W:0] DEPTH_X = (LINK_W+1)'(RECORD_DEPTH);
  localparam logic [AW:0]     DEPTH_A = (AW+1)'(RECORD_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LIST
  } state_t;

  state_t              state;
  logic [LINK_W-1:0]   walk_index;
  logic                walk_failed;
  logic [AW-1:0]       idx;
  logic [CW-1:0]       count;
  logic [LETTER_W-1:0] want;

  // Result queue
  out_item_t  oq [2];
  logic       oq_wptr;
  logic       oq_rptr;
  logic [1:0] oq_cnt;
  logic       oq_full;
  logic       out_push;
  out_item_t  out_data;
  logic       out_pop;

  // Record memory
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [RECORD_W-1:0] rdata;

  logic                accept;
  logic                walk_oob;
  logic [AW:0]         idx_inc;
  logic                at_end;
  logic [CW-1:0]       count_inc;
  logic                rec_more;
  logic [LETTER_W-1:0] rec_letter;
  logic [LINK_W-1:0]   rec_link;
  logic                walk_hit;
  logic                walk_stop;
  logic                list_last;
  logic                list_trunc;

  dpw_ram #(
    .WIDTH(RECORD_W),
    .DEPTH(RECORD_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cmd.record_word),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  assign rec_more   = rdata[REC_MORE_BIT];
  assign rec_letter = rdata[REC_LETTER_HI:REC_LETTER_LO];
  assign rec_link   = rdata[LINK_W-1:0];

  assign walk_oob  = ({1'b0, walk_index} >= DEPTH_X);
  assign idx_inc   = {1'b0, idx} + (AW+1)'(1);
  assign at_end    = (idx_inc == DEPTH_A);
  assign count_inc = count + CW'(1);

  assign walk_hit   = (rec_letter == want);
  assign walk_stop  = !rec_more || at_end;
  assign list_trunc = rec_more && (count_inc == CW'(MAX_CHILDREN));
  assign list_last  = !rec_more || list_trunc || at_end;

  assign oq_full = (oq_cnt == 2'd2);
  assign empty   = (oq_cnt == 2'd0);
  assign result  = oq[oq_rptr];
  assign out_pop = pop && !empty;

  // Hold word and list queries until the result queue has room
  always_comb begin
    cmd_ready = 1'b0;
    if (state == ST_IDLE) begin
      case (cmd.op)
        OP_WORD,
        OP_LIST: cmd_ready = !oq_full;
        default: cmd_ready = 1'b1;
      endcase
    end
  end

  assign accept    = cmd_valid && cmd_ready;
  assign ram_we    = accept && (cmd.op == OP_WRITE) && cmd.addr_ok;
  assign ram_waddr = AW'((LINK_W+1)'(cmd.address));

  // Idle: prefetch the head of the current run. Scanning: fetch the next record.
  always_comb begin
    ram_raddr = idx_inc[AW-1:0];
    ram_re    = 1'b0;
    case (state)
      ST_IDLE: begin
        ram_raddr = walk_index[AW-1:0];
        ram_re    = 1'b1;
      end
      ST_WALK: ram_re = !walk_hit && !walk_stop;
      ST_LIST: ram_re = !oq_full && !list_last;
      default: ram_re = 1'b0;
    endcase
  end

  always_comb begin
    out_push = 1'b0;
    out_data = '0;
    case (state)
      ST_IDLE: begin
        if (accept && cmd.op == OP_WORD) begin
          out_push             = 1'b1;
          out_data.found       = !walk_failed;
          out_data.last_result = 1'b1;
        end else if (accept && cmd.op == OP_LIST && (walk_failed || walk_oob)) begin
          out_push             = 1'b1;
          out_data.empty_list  = 1'b1;
          out_data.last_result = 1'b1;
        end
      end
      ST_LIST: begin
        if (!oq_full) begin
          out_push              = 1'b1;
          out_data.child_letter = rec_letter;
          out_data.truncated    = list_trunc;
          out_data.last_result  = list_last;
        end
      end
      default: out_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      oq[oq_wptr] <= out_data;
    end
    if (rst) begin
      oq_wptr <= 1'b0;
      oq_rptr <= 1'b0;
      oq_cnt  <= 2'd0;
    end else begin
      if (out_push) begin
        oq_wptr <= ~oq_wptr;
      end
      if (out_pop) begin
        oq_rptr <= ~oq_rptr;
      end
      oq_cnt <= oq_cnt + 2'(out_push) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      walk_index  <= '0;
      walk_failed <= 1'b0;
      idx         <= '0;
      count       <= '0;
      want        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd.op)
              OP_WALK: begin
                if (!walk_failed) begin
                  if (walk_oob) begin
                    walk_failed <= 1'b1;
                  end else begin
                    idx   <= walk_index[AW-1:0];
                    want  <= cmd.letter;
                    state <= ST_WALK;
                  end
                end
              end
              OP_WORD: begin
                walk_index  <= '0;
                walk_failed <= 1'b0;
              end
              OP_LIST: begin
                if (walk_failed || walk_oob) begin
                  walk_index  <= '0;
                  walk_failed <= 1'b0;
                end else begin
                  idx   <= walk_index[AW-1:0];
                  count <= '0;
                  state <= ST_LIST;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_WALK: begin
          if (walk_hit) begin
            walk_index <= rec_link;
            state      <= ST_IDLE;
          end else if (walk_stop) begin
            walk_failed <= 1'b1;
            state       <= ST_IDLE;
          end else begin
            idx <= idx_inc[AW-1:0];
          end
        end
        ST_LIST: begin
          if (!oq_full) begin
            if (list_last) begin
              walk_index  <= '0;
              walk_failed <= 1'b0;
              state       <= ST_IDLE;
            end else begin
              idx   <= idx_inc[AW-1:0];
              count <= count_inc;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dawg_prefix_walker.sv =====
// dawg_prefix_walker: walks a word graph held in an on-chip record memory.
// Requests enter through a queue-style port: drive item and push; a request
// is taken on a clock edge with push high and full low. Results leave the
// same way: while empty is low the oldest result sits on result; raise pop
// to take it. Write requests load one 32-bit record (more bit, letter, link);
// walk requests scan the current sibling run for a letter and follow its
// link; a word query returns one result; a list query returns every child
// letter of the walked prefix, cut at MAX_CHILDREN, or one empty-list
// result after a failed walk. Both queries send the walk back to the root.
// Each request waits in the two-entry front queue before the engine takes it;
// the engine takes a new request only when idle, so a walk or a list ends
// before the next request starts. Records are scanned one record per cycle
// via the single read port, held in a list while the result queue is full.
// Reset clears the walk state and both queues; records are not cleared and
// must be written before they are read. When the receiver stops popping,
// the two-entry result queue fills, the engine holds, and full rises once
// the request queue backs up.
`default_nettype none

module dawg_prefix_walker
  import dpw_pkg::*;
#(
  parameter int RECORD_DEPTH = DEF_RECORD_DEPTH,
  parameter int MAX_CHILDREN = DEF_MAX_CHILDREN
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output      logic      full,
  input  wire in_item_t  item,
  output      logic      empty,
  input  wire logic      pop,
  output      out_item_t result
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Front: take and decode requests, buffer them for the engine
  dpw_front #(
    .RECORD_DEPTH(RECORD_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  // Back: record memory, walk state and result queue
  dpw_back #(
    .RECORD_DEPTH(RECORD_DEPTH),
    .MAX_CHILDREN(MAX_CHILDREN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

`default_nettype wire
